// ===== rtl/mono_note_sine_oscillator_assert.svh =====
// Assertion macros for the sine voice; they expand to nothing when SYNTH is set.
// The macros sample on clk and are disabled while arst_n is low.
`ifndef MONO_NOTE_SINE_OSCILLATOR_ASSERT_SVH
`define MONO_NOTE_SINE_OSCILLATOR_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define MNSO_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define MNSO_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MNSO_ASSERT_IMP(label, ante, cons, msg)
`define MNSO_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/mnso_pkg.sv =====
package mnso_pkg;

	// field widths
	localparam int KEY_W     = 7;
	localparam int KIND_W    = 2;
	localparam int SAMPLE_W  = 14;
	localparam int STEP_W    = 28;
	localparam int FREQ_W    = 30;
	localparam int KEY_COUNT = 1 << KEY_W;

	// config port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_STEP_PER_HZ = 1'b0;
	localparam logic [STEP_W-1:0] STEP_RESET = 28'd22906492;

	// transaction kinds
	localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd2;

	// sine table shape
	localparam int SINE_ENTRIES = 1024;
	localparam int SAMPLE_BITS  = 16;
	localparam int IDX_W        = $clog2(SINE_ENTRIES);

	// phase step = freq (Q16.16) * step_per_hz (2^40 / fs), scaled to 2^56
	localparam int STEP_SCALE = 56;

	// fixed-point sine evaluation
	localparam int Q_FRAC       = 30;
	localparam int HORNER_TERMS = 6;
	localparam logic [63:0] Q30_ONE     = 64'd1 << Q_FRAC;
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam logic [63:0] SINE_N      = 64'(SINE_ENTRIES);
	localparam logic [63:0] MAG_HALF    = 64'd5 << Q_FRAC;
	localparam logic [63:0] MAG_DIV     = 64'd10 << Q_FRAC;
	localparam logic [63:0] HORNER_DIV [HORNER_TERMS] = '{
		64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6
	};

	// equal-tempered note table, octave 9 in Q16.16
	localparam int OCT_NOTES = 12;
	localparam logic [63:0] OCT_NOTES_W = 64'd12;
	localparam logic [63:0] TOP_OCT     = 64'd10;
	localparam logic [63:0] TOP_OCTAVE [OCT_NOTES] = '{
		64'd548668578, 64'd581294109, 64'd615859655, 64'd652480576,
		64'd691279090, 64'd732384684, 64'd775934544, 64'd822074013,
		64'd870957077, 64'd922746880, 64'd977616265, 64'd1035748353
	};

	typedef logic [SINE_ENTRIES-1:0][SAMPLE_W-1:0] sine_rom_t;
	typedef logic [KEY_COUNT-1:0][FREQ_W-1:0] freq_rom_t;

	// sin(pi/2 * u) in Q30, Horner-form Taylor series, clamped to one
	function automatic logic [63:0] quarter_sine(input logic [63:0] u30);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		x = (u30 * PI_HALF_Q30) >> Q_FRAC;
		x2 = (x * x) >> Q_FRAC;
		t = Q30_ONE;
		for (int k = 0; k < HORNER_TERMS; k++) begin
			t = Q30_ONE - ((x2 * t) >> Q_FRAC) / HORNER_DIV[3'(k)];
		end
		t = (x * t) >> Q_FRAC;
		return (t > Q30_ONE) ? Q30_ONE : t;
	endfunction

	// one signed table entry, 0.8 of the 14-bit full scale, masked to the sample width
	function automatic logic [SAMPLE_W-1:0] sine_entry(input logic [63:0] idx);
		logic [63:0] r;
		logic [63:0] quad;
		logic [63:0] rem;
		logic [63:0] num;
		logic [63:0] s;
		logic [63:0] mag;
		logic [63:0] val;
		r = idx << 2;
		quad = (r / SINE_N) & 64'd3;
		rem = r % SINE_N;
		num = quad[0] ? (SINE_N - rem) : rem;
		s = quarter_sine((num << Q_FRAC) / SINE_N);
		mag = ((s << SAMPLE_BITS) + MAG_HALF) / MAG_DIV;
		val = quad[1] ? (64'd0 - mag) : mag;
		return val[SAMPLE_W-1:0];
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int i = 0; i < SINE_ENTRIES; i++) begin
			rom[IDX_W'(i)] = sine_entry(64'(i));
		end
		return rom;
	endfunction

	// Q16.16 frequency of a key: top-octave value halved per octave, rounded half up
	function automatic logic [FREQ_W-1:0] note_freq(input logic [63:0] key);
		logic [63:0] oct;
		logic [63:0] semi;
		logic [63:0] sh;
		logic [63:0] f;
		oct = key / OCT_NOTES_W;
		semi = key % OCT_NOTES_W;
		sh = TOP_OCT - oct;
		f = (((TOP_OCTAVE[semi[3:0]] << 1) >> sh) + 64'd1) >> 1;
		return f[FREQ_W-1:0];
	endfunction

	function automatic freq_rom_t build_freq_rom();
		freq_rom_t rom;
		for (int i = 0; i < KEY_COUNT; i++) begin
			rom[KEY_W'(i)] = note_freq(64'(i));
		end
		return rom;
	endfunction

endpackage

// ===== rtl/mono_note_sine_oscillator.sv =====
// Monophonic sine voice: note-on/note-off gate and a phase-accumulator oscillator.
// A tick passes the input reg, index reg and output reg in turn and needs one accumulator add and
// one sine-ROM read. Throughput: one transaction per cycle unless result_stall holds the pipeline.
// Note events update the voice state as they leave stage 1 and produce no result.
// Reset (arst_n low) empties the pipeline, clears gate, key, phase and step, and sets step_per_hz
// to its 48 kHz value; the sine and note tables are constants and need no clearing pass.
`include "mono_note_sine_oscillator_assert.svh"

module mono_note_sine_oscillator #(
	parameter int PHASE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,

	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [mnso_pkg::PADDR_W-1:0] paddr,
	input  logic [mnso_pkg::PDATA_W-1:0] pwdata,
	output logic [mnso_pkg::PDATA_W-1:0] prdata,
	output logic pready,

	input  logic item_valid,
	output logic item_stall,
	input  logic [mnso_pkg::KIND_W-1:0] kind,
	input  logic [mnso_pkg::KEY_W-1:0] note_key,

	output logic result_valid,
	input  logic result_stall,
	output logic signed [mnso_pkg::SAMPLE_W-1:0] sample,
	output logic gate
);

	localparam int PROD_W      = mnso_pkg::FREQ_W + mnso_pkg::STEP_W;
	localparam int PHASE_SHIFT = mnso_pkg::STEP_SCALE - PHASE_BITS;
	localparam int IDXP_W      = PHASE_BITS + mnso_pkg::IDX_W;

	localparam mnso_pkg::sine_rom_t SINE_ROM = mnso_pkg::build_sine_rom();
	localparam mnso_pkg::freq_rom_t FREQ_ROM = mnso_pkg::build_freq_rom();

	// config register
	logic [mnso_pkg::STEP_W-1:0] step_q;
	logic cfg_index;
	logic cfg_write;

	// stage 1: accepted transaction with its note frequency
	logic valid_s1;
	logic [mnso_pkg::KIND_W-1:0] kind_s1;
	logic [mnso_pkg::KEY_W-1:0] key_s1;
	logic [mnso_pkg::FREQ_W-1:0] freq_s1;

	// stage 2: table index of a tick
	logic valid_s2;
	logic gate_s2;
	logic [mnso_pkg::IDX_W-1:0] idx_s2;

	// voice state
	logic gate_on_q;
	logic [mnso_pkg::KEY_W-1:0] held_note_q;
	logic [PHASE_BITS-1:0] phase_acc_q;
	logic [PHASE_BITS-1:0] phase_inc_q;

	// output register
	logic result_valid_q;
	logic gate_q;
	logic signed [mnso_pkg::SAMPLE_W-1:0] sample_q;

	// flow control
	logic out_free;
	logic s2_go;
	logic s2_free;
	logic s1_tick;
	logic s1_go;
	logic item_take;

	// datapath
	logic [PROD_W-1:0] inc_prod;
	logic [PHASE_BITS-1:0] new_inc;
	logic [IDXP_W-1:0] idx_prod;
	logic [mnso_pkg::IDX_W-1:0] idx_now;
	logic [PHASE_BITS-1:0] phase_next;

	// APB decode; register index sits above the byte offset
	assign cfg_index = paddr[mnso_pkg::PADDR_W-1];
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (cfg_index == mnso_pkg::REG_STEP_PER_HZ) begin
			prdata = mnso_pkg::PDATA_W'(step_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= mnso_pkg::STEP_RESET;
		end else if (cfg_write && cfg_index == mnso_pkg::REG_STEP_PER_HZ) begin
			step_q <= pwdata[mnso_pkg::STEP_W-1:0];
		end
	end

	// per-stage advance; only ticks need a slot downstream
	assign out_free   = !result_valid_q || !result_stall;
	assign s2_go      = valid_s2 && out_free;
	assign s2_free    = !valid_s2 || s2_go;
	assign s1_tick    = (kind_s1 == mnso_pkg::KIND_TICK);
	assign s1_go      = valid_s1 && (!s1_tick || s2_free);
	assign item_stall = valid_s1 && !s1_go;
	assign item_take  = item_valid && !item_stall;

	// phase step for a note-on, kept modulo 2^PHASE_BITS
	assign inc_prod = PROD_W'(freq_s1) * PROD_W'(step_q);
	assign new_inc  = inc_prod[PHASE_SHIFT +: PHASE_BITS];

	// table index and next phase for a tick
	assign idx_prod   = IDXP_W'(phase_acc_q) * IDXP_W'(mnso_pkg::SINE_ENTRIES);
	assign idx_now    = idx_prod[PHASE_BITS +: mnso_pkg::IDX_W];
	assign phase_next = phase_acc_q + phase_inc_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_take) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go && s1_tick) begin
				valid_s2 <= 1'b1;
			end else if (s2_go) begin
				valid_s2 <= 1'b0;
			end
			if (s2_go) begin
				result_valid_q <= 1'b1;
			end else if (out_free) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// stage 1 payload, note frequency looked up on the way in
	always_ff @(posedge clk) begin
		if (item_take) begin
			kind_s1 <= kind;
			key_s1  <= note_key;
			freq_s1 <= FREQ_ROM[note_key];
		end
	end

	// voice state commits as a transaction leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_on_q   <= 1'b0;
			held_note_q <= '0;
			phase_acc_q <= '0;
			phase_inc_q <= '0;
		end else if (s1_go) begin
			unique case (kind_s1)
				mnso_pkg::KIND_NOTE_ON: begin
					gate_on_q   <= 1'b1;
					held_note_q <= key_s1;
					phase_inc_q <= new_inc;
				end
				mnso_pkg::KIND_NOTE_OFF: begin
					if (key_s1 == held_note_q) begin
						gate_on_q <= 1'b0;
					end
				end
				mnso_pkg::KIND_TICK: begin
					phase_acc_q <= gate_on_q ? phase_next : '0;
				end
				default: begin
				end
			endcase
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (s1_go && s1_tick) begin
			gate_s2 <= gate_on_q;
			idx_s2  <= idx_now;
		end
	end

	// sine ROM read into the output register
	always_ff @(posedge clk) begin
		if (s2_go) begin
			gate_q   <= gate_s2;
			sample_q <= gate_s2 ? $signed(SINE_ROM[idx_s2]) : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign sample       = sample_q;
	assign gate         = gate_q;

	// checks
	`MNSO_ASSERT_IMP(a_ungated_silent, result_valid_q && !gate_q, sample_q == '0, "ungated result has a nonzero sample")
	`MNSO_ASSERT_NXT(a_tick_off_clears_phase, s1_go && s1_tick && !gate_on_q, phase_acc_q == '0, "phase not cleared by ungated tick")
	`MNSO_ASSERT_NXT(a_note_on_latches, s1_go && kind_s1 == mnso_pkg::KIND_NOTE_ON, gate_on_q && held_note_q == $past(key_s1), "note-on did not latch gate and key")
	`MNSO_ASSERT_IMP(a_stall_only_when_full, item_stall, valid_s1 && valid_s2 && result_valid_q, "input stalled with a free stage")

endmodule
